>>> rtl/mtfr_pkg.sv
// Shared constants, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps
package mtfr_pkg;

   localparam int MAX_POINTS  = 10;
   localparam int SLOT_IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W       = $clog2(MAX_POINTS + 1);

   localparam int COORD_W     = 12;
   localparam int SLOT_W      = 4;
   localparam int KIND_W      = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 32;

   localparam logic [7:0] EMPTY_BYTE    = 8'hFF;
   localparam logic [7:0] STATUS_DOWN   = 8'd1;
   localparam logic [7:0] STATUS_MOVE   = 8'd2;

   localparam logic [KIND_W-1:0] KIND_CONTACT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SYNC    = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_SWAP_AXES     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MIRROR_X      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MIRROR_Y      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_WIDTH_MAX     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_HEIGHT_MAX    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SCREEN_ACTIVE = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_POINTS_IN_USE = 3'd6;

   typedef struct packed {
      logic capture;
      logic emit_contact;
      logic emit_release;
      logic emit_sync;
      logic scan_step;
      logic frame_done;
   } cmd_type;

   typedef struct packed {
      logic contact;
      logic frame_end;
      logic scan_done;
      logic gone_bit;
      logic frame_reported;
      logic out_free;
   } status_type;

endpackage

>>> rtl/multitouch_frame_reporter.sv
// Top level of the multitouch frame reporter.
//
//   Channel  Direction  Contents
//   req_     in         one touch point record per request, tlast on the frame's last record
//   rsp_     out        contact, slot release or frame sync reports, tlast on a request's last
//   csr_     in         register writes, index in csr_addr
//
// A record that is not the last of its frame is captured, then reported once its result can be stored.
// The last record of a frame then walks the release scan, closes it and emits the frame sync
// when the frame reported anything; the scan covers points_in_use slots saturated at 10,
// one slot per cycle while no release waits for a stalled result register.
// A stalled result register holds the controller until rsp_tready frees it.
// Reset is synchronous and restores all register defaults and clears the slot state.
`timescale 1ns / 1ps
module multitouch_frame_reporter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // x_high, x_low, y_high, y_low, touch_status, point_id
   input  logic [mtfr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // slot, pos_x, pos_y, zero fill
   output logic [mtfr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // report_kind
   output logic [mtfr_pkg::KIND_W-1:0]     rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [mtfr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [mtfr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mtfr_pkg::*;

   cmd_type    cmd;
   status_type status;

   mtfr_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   mtfr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

>>> rtl/mtfr_datapath.sv
// Datapath: configuration registers, slot state, request capture and result register.
`timescale 1ns / 1ps
module mtfr_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mtfr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [mtfr_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [mtfr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mtfr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [mtfr_pkg::KIND_W-1:0]     rsp_tuser,
   output logic                            rsp_tlast,
   input  mtfr_pkg::cmd_type               cmd,
   output mtfr_pkg::status_type            status
);
   import mtfr_pkg::*;

   logic                  swap_axes_ff, swap_axes_in;
   logic                  mirror_x_ff, mirror_x_in;
   logic                  mirror_y_ff, mirror_y_in;
   logic [COORD_W-1:0]    width_max_ff, width_max_in;
   logic [COORD_W-1:0]    height_max_ff, height_max_in;
   logic                  active_ff, active_in;
   logic [3:0]            points_ff, points_in;

   logic [MAX_POINTS-1:0] prev_pressed_ff, prev_pressed_in;
   logic [MAX_POINTS-1:0] cur_pressed_ff, cur_pressed_in;
   logic                  reported_ff, reported_in;

   logic                  contact_ff, contact_in;
   logic                  frame_end_ff, frame_end_in;
   logic [COORD_W-1:0]    raw_x_ff, raw_x_in;
   logic [COORD_W-1:0]    raw_y_ff, raw_y_in;
   logic [SLOT_IDX_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]      scan_idx_ff, scan_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [COORD_W-1:0]    rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0]    rsp_y_ff, rsp_y_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]      slot_count;
   logic [7:0]            x_high, x_low, y_high, y_low, touch_status, point_id;
   logic [7:0]            slot_raw;
   logic [COORD_W-1:0]    sel_x, sel_y, pos_x, pos_y;
   logic [MAX_POINTS-1:0] gone;
   logic                  out_free;
   logic                  emit_any;

   assign x_high       = req_tdata[7:0];
   assign x_low        = req_tdata[15:8];
   assign y_high       = req_tdata[23:16];
   assign y_low        = req_tdata[31:24];
   assign touch_status = req_tdata[39:32];
   assign point_id     = req_tdata[47:40];
   assign slot_raw     = point_id - 8'd1;

   assign slot_count = (int'(points_ff) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                      : CNT_W'(points_ff);

   assign gone     = prev_pressed_ff & ~cur_pressed_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit_any = cmd.emit_contact || cmd.emit_release || cmd.emit_sync;

   // Axis swap, then mirror against the panel maximum with clamping at zero.
   assign sel_x = swap_axes_ff ? raw_y_ff : raw_x_ff;
   assign sel_y = swap_axes_ff ? raw_x_ff : raw_y_ff;
   assign pos_x = !mirror_x_ff ? sel_x :
                  (sel_x > width_max_ff) ? '0 : width_max_ff - sel_x;
   assign pos_y = !mirror_y_ff ? sel_y :
                  (sel_y > height_max_ff) ? '0 : height_max_ff - sel_y;

   always_comb begin
      swap_axes_in  = swap_axes_ff;
      mirror_x_in   = mirror_x_ff;
      mirror_y_in   = mirror_y_ff;
      width_max_in  = width_max_ff;
      height_max_in = height_max_ff;
      active_in     = active_ff;
      points_in     = points_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_SWAP_AXES:     swap_axes_in  = csr_wdata[0];
            REG_MIRROR_X:      mirror_x_in   = csr_wdata[0];
            REG_MIRROR_Y:      mirror_y_in   = csr_wdata[0];
            REG_WIDTH_MAX:     width_max_in  = csr_wdata[COORD_W-1:0];
            REG_HEIGHT_MAX:    height_max_in = csr_wdata[COORD_W-1:0];
            REG_SCREEN_ACTIVE: active_in     = csr_wdata[0];
            REG_POINTS_IN_USE: points_in     = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      contact_in   = contact_ff;
      frame_end_in = frame_end_ff;
      raw_x_in     = raw_x_ff;
      raw_y_in     = raw_y_ff;
      slot_in      = slot_ff;
      scan_idx_in  = scan_idx_ff;
      if (cmd.capture) begin
         contact_in   = (x_high != EMPTY_BYTE) && (y_high != EMPTY_BYTE) &&
                        ((touch_status == STATUS_DOWN) || (touch_status == STATUS_MOVE)) &&
                        (point_id != 8'd0) && (point_id <= 8'(slot_count)) && active_ff;
         frame_end_in = req_tlast;
         raw_x_in     = {x_high, x_low[3:0]};
         raw_y_in     = {y_high, y_low[3:0]};
         slot_in      = slot_raw[SLOT_IDX_W-1:0];
         scan_idx_in  = '0;
      end else if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
      end
   end

   always_comb begin
      prev_pressed_in = prev_pressed_ff;
      cur_pressed_in  = cur_pressed_ff;
      reported_in     = reported_ff;
      if (cmd.emit_contact) begin
         cur_pressed_in[slot_ff] = 1'b1;
         reported_in             = 1'b1;
      end
      if (cmd.emit_release) begin
         reported_in = 1'b1;
      end
      if (cmd.frame_done) begin
         prev_pressed_in = cur_pressed_ff;
         cur_pressed_in  = '0;
         reported_in     = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = emit_any || (rsp_valid_ff && !rsp_tready);
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit_contact) begin
         rsp_kind_in = KIND_CONTACT;
         rsp_slot_in = SLOT_W'(slot_ff);
         rsp_x_in    = pos_x;
         rsp_y_in    = pos_y;
         rsp_last_in = !frame_end_ff;
      end else if (cmd.emit_release) begin
         rsp_kind_in = KIND_RELEASE;
         rsp_slot_in = SLOT_W'(scan_idx_ff[SLOT_IDX_W-1:0]);
         rsp_x_in    = '0;
         rsp_y_in    = '0;
         rsp_last_in = 1'b0;
      end else if (cmd.emit_sync) begin
         rsp_kind_in = KIND_SYNC;
         rsp_slot_in = '0;
         rsp_x_in    = '0;
         rsp_y_in    = '0;
         rsp_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_axes_ff    <= 1'b1;
         mirror_x_ff     <= 1'b0;
         mirror_y_ff     <= 1'b1;
         width_max_ff    <= 12'd2048;
         height_max_ff   <= 12'd1536;
         active_ff       <= 1'b1;
         points_ff       <= 4'd10;
         prev_pressed_ff <= '0;
         cur_pressed_ff  <= '0;
         reported_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         swap_axes_ff    <= swap_axes_in;
         mirror_x_ff     <= mirror_x_in;
         mirror_y_ff     <= mirror_y_in;
         width_max_ff    <= width_max_in;
         height_max_ff   <= height_max_in;
         active_ff       <= active_in;
         points_ff       <= points_in;
         prev_pressed_ff <= prev_pressed_in;
         cur_pressed_ff  <= cur_pressed_in;
         reported_ff     <= reported_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      contact_ff   <= contact_in;
      frame_end_ff <= frame_end_in;
      raw_x_ff     <= raw_x_in;
      raw_y_ff     <= raw_y_in;
      slot_ff      <= slot_in;
      scan_idx_ff  <= scan_idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      status.contact        = contact_ff;
      status.frame_end      = frame_end_ff;
      status.scan_done      = (scan_idx_ff >= slot_count);
      status.gone_bit       = (scan_idx_ff < slot_count) &&
                              gone[scan_idx_ff[SLOT_IDX_W-1:0]];
      status.frame_reported = reported_ff;
      status.out_free       = out_free;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_y_ff, rsp_x_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/mtfr_controller.sv
// Controller: sequences capture, contact report, release scan and frame sync.
`timescale 1ns / 1ps
module mtfr_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output mtfr_pkg::cmd_type    cmd,
   input  mtfr_pkg::status_type status
);
   import mtfr_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_CONTACT = 2'd1;
   localparam logic [1:0] ST_SCAN    = 2'd2;
   localparam logic [1:0] ST_SYNC    = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CONTACT;
            end
         end
         ST_CONTACT: begin
            if (!status.contact || status.out_free) begin
               cmd.emit_contact = status.contact;
               state_in         = status.frame_end ? ST_SCAN : ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_SYNC;
            end else if (!status.gone_bit || status.out_free) begin
               cmd.emit_release = status.gone_bit;
               cmd.scan_step    = 1'b1;
            end
         end
         ST_SYNC: begin
            if (!status.frame_reported || status.out_free) begin
               cmd.emit_sync  = status.frame_reported;
               cmd.frame_done = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sim/tb.sv
// Self-checking testbench for the multitouch frame reporter with a built-in report predictor.
`timescale 1ns / 1ps
module tb;
   import mtfr_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RESULT_CAP = 12;
   localparam int PHASE_ITEMS = 38;
   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 3'd7;

   typedef struct {
      logic [7:0] x_high;
      logic [7:0] x_low;
      logic [7:0] y_high;
      logic [7:0] y_low;
      logic [7:0] touch_status;
      logic [7:0] point_id;
      logic       frame_end;
   } point_record_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [SLOT_W-1:0]  slot;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic               last;
   } touch_report_type;

   class frame_report_predictor;
      logic                   swap_axes = 1'b1;
      logic                   mirror_x = 1'b0;
      logic                   mirror_y = 1'b1;
      logic [COORD_W-1:0]     width_max = 12'd2048;
      logic [COORD_W-1:0]     height_max = 12'd1536;
      logic                   screen_active = 1'b1;
      logic [3:0]             points_in_use = 4'd10;
      logic [MAX_POINTS-1:0]  prev_pressed = '0;
      logic [MAX_POINTS-1:0]  cur_pressed = '0;
      logic                   frame_reported = 1'b0;
      touch_report_type       pending_reports[$];
      int                     mismatches = 0;

      function void set_reg(logic [CSR_ADDR_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_SWAP_AXES: swap_axes = value[0];
            REG_MIRROR_X: mirror_x = value[0];
            REG_MIRROR_Y: mirror_y = value[0];
            REG_WIDTH_MAX: width_max = value;
            REG_HEIGHT_MAX: height_max = value;
            REG_SCREEN_ACTIVE: screen_active = value[0];
            REG_POINTS_IN_USE: points_in_use = value[3:0];
            default: ;
         endcase
      endfunction

      function int slot_total();
         return (points_in_use > MAX_POINTS) ? MAX_POINTS : points_in_use;
      endfunction

      function logic [COORD_W-1:0] mirror_axis(logic [COORD_W-1:0] maxv,
                                               logic [COORD_W-1:0] v);
         return (v > maxv) ? '0 : maxv - v;
      endfunction

      function void take_record(point_record_type r);
         touch_report_type   batch[$];
         touch_report_type   rep;
         logic [COORD_W-1:0] rx;
         logic [COORD_W-1:0] ry;
         logic [MAX_POINTS-1:0] gone;
         int                 cnt;
         cnt = slot_total();
         if (r.x_high != EMPTY_BYTE && r.y_high != EMPTY_BYTE &&
             (r.touch_status == STATUS_DOWN || r.touch_status == STATUS_MOVE) &&
             r.point_id >= 1 && r.point_id <= cnt && screen_active) begin
            rx = {r.x_high, r.x_low[3:0]};
            ry = {r.y_high, r.y_low[3:0]};
            rep.kind = KIND_CONTACT;
            rep.slot = SLOT_W'(r.point_id - 8'd1);
            rep.pos_x = swap_axes ? ry : rx;
            rep.pos_y = swap_axes ? rx : ry;
            if (mirror_x) rep.pos_x = mirror_axis(width_max, rep.pos_x);
            if (mirror_y) rep.pos_y = mirror_axis(height_max, rep.pos_y);
            rep.last = 1'b0;
            batch.push_back(rep);
            cur_pressed[r.point_id - 1] = 1'b1;
            frame_reported = 1'b1;
         end
         if (r.frame_end) begin
            gone = prev_pressed & ~cur_pressed;
            for (int i = 0; i < cnt; i++) begin
               if (gone[i]) begin
                  rep.kind = KIND_RELEASE;
                  rep.slot = SLOT_W'(i);
                  rep.pos_x = '0;
                  rep.pos_y = '0;
                  rep.last = 1'b0;
                  if (batch.size() < RESULT_CAP) batch.push_back(rep);
                  frame_reported = 1'b1;
               end
            end
            if (frame_reported) begin
               rep.kind = KIND_SYNC;
               rep.slot = '0;
               rep.pos_x = '0;
               rep.pos_y = '0;
               rep.last = 1'b0;
               if (batch.size() < RESULT_CAP) batch.push_back(rep);
            end
            prev_pressed = cur_pressed;
            cur_pressed = '0;
            frame_reported = 1'b0;
         end
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) pending_reports.push_back(batch[i]);
      endfunction

      function void match_report(touch_report_type got);
         touch_report_type want;
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report kind=%0d slot=%0d x=%0d y=%0d last=%0b",
                     $time, got.kind, got.slot, got.pos_x, got.pos_y, got.last);
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         if (got.kind !== want.kind || got.slot !== want.slot || got.pos_x !== want.pos_x ||
             got.pos_y !== want.pos_y || got.last !== want.last) begin
            $display("%0t: report mismatch, expected kind=%0d slot=%0d x=%0d y=%0d last=%0b",
                     $time, want.kind, want.slot, want.pos_x, want.pos_y, want.last);
            $display("%0t:                  actual kind=%0d slot=%0d x=%0d y=%0d last=%0b",
                     $time, got.kind, got.slot, got.pos_x, got.pos_y, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int send_idle_pct = 33;
   int recv_idle_pct = 77;
   int stall_cycles = 0;
   frame_report_predictor pred = new;

   multitouch_frame_reporter dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      touch_report_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.slot = rsp_tdata[3:0];
         got.pos_x = rsp_tdata[15:4];
         got.pos_y = rsp_tdata[27:16];
         got.last = rsp_tlast;
         pred.match_report(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic point_record_type make_record(logic [7:0] xh, logic [7:0] xl,
                                                    logic [7:0] yh, logic [7:0] yl,
                                                    logic [7:0] st, logic [7:0] id,
                                                    logic fend);
      point_record_type r;
      r.x_high = xh;
      r.x_low = xl;
      r.y_high = yh;
      r.y_low = yl;
      r.touch_status = st;
      r.point_id = id;
      r.frame_end = fend;
      return r;
   endfunction

   function automatic point_record_type random_record(logic fend);
      point_record_type r;
      int cnt;
      cnt = pred.slot_total();
      r.x_low = 8'($urandom_range(0, 255));
      r.y_low = 8'($urandom_range(0, 255));
      r.frame_end = fend;
      if ($urandom_range(99) < 80) begin
         r.x_high = 8'($urandom_range(0, 254));
         r.y_high = 8'($urandom_range(0, 254));
         r.touch_status = 8'($urandom_range(STATUS_DOWN, STATUS_MOVE));
         r.point_id = (cnt == 0) ? 8'($urandom_range(1, MAX_POINTS))
                                 : 8'($urandom_range(1, cnt));
      end else begin
         r.x_high = ($urandom_range(3) == 0) ? EMPTY_BYTE : 8'($urandom_range(0, 255));
         r.y_high = ($urandom_range(3) == 0) ? EMPTY_BYTE : 8'($urandom_range(0, 255));
         r.touch_status = 8'($urandom_range(0, 255));
         r.point_id = 8'($urandom_range(0, 255));
      end
      return r;
   endfunction

   task automatic send_record(point_record_type r);
      req_tdata <= {r.point_id, r.touch_status, r.y_low, r.y_high, r.x_low, r.x_high};
      req_tlast <= r.frame_end;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pred.take_record(r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic wait_drained();
      while (pred.pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] index, int value, int width);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] data;
      mask = CSR_DATA_W'((1 << width) - 1);
      data = (CSR_DATA_W'($urandom) & ~mask) | (CSR_DATA_W'(value) & mask);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= data;
      @(posedge clock);
      pred.set_reg(index, data);
   endtask

   task automatic apply_settings(int swap, int mx, int my, int wmax, int hmax,
                                 int active, int points);
      write_reg(REG_SWAP_AXES, swap, 1);
      write_reg(REG_MIRROR_X, mx, 1);
      write_reg(REG_MIRROR_Y, my, 1);
      write_reg(REG_WIDTH_MAX, wmax, COORD_W);
      write_reg(REG_HEIGHT_MAX, hmax, COORD_W);
      write_reg(REG_SCREEN_ACTIVE, active, 1);
      write_reg(REG_POINTS_IN_USE, points, 4);
      csr_we <= 1'b0;
   endtask

   task automatic run_frames(int quota);
      int sent;
      int len;
      sent = 0;
      while (sent < quota) begin
         len = $urandom_range(1, 6);
         for (int k = 0; k < len; k++) send_record(random_record(k == len - 1));
         sent += len;
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      point_record_type opening[$];
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      opening.push_back(make_record(8'hFE, 8'hF5, 8'h00, 8'h0A, STATUS_DOWN, 8'd1, 1'b0));
      opening.push_back(make_record(8'h00, 8'h00, 8'hFE, 8'hFF, STATUS_MOVE, 8'd10, 1'b0));
      opening.push_back(make_record(8'h10, 8'h00, 8'h10, 8'h00, STATUS_DOWN, 8'd0, 1'b0));
      opening.push_back(make_record(8'h10, 8'h00, 8'h10, 8'h00, STATUS_DOWN, 8'd11, 1'b0));
      opening.push_back(make_record(8'h10, 8'h00, 8'h10, 8'h00, STATUS_DOWN, 8'd255, 1'b0));
      opening.push_back(make_record(EMPTY_BYTE, 8'h00, 8'h10, 8'h00, STATUS_DOWN, 8'd2, 1'b0));
      opening.push_back(make_record(8'h10, 8'h00, EMPTY_BYTE, 8'h00, STATUS_DOWN, 8'd2, 1'b0));
      opening.push_back(make_record(8'h10, 8'h00, 8'h10, 8'h00, 8'd0, 8'd3, 1'b0));
      opening.push_back(make_record(8'h10, 8'h00, 8'h10, 8'h00, 8'd3, 8'd3, 1'b0));
      opening.push_back(make_record(8'h10, 8'h00, 8'h10, 8'h00, 8'd255, 8'd3, 1'b0));
      opening.push_back(make_record(8'h20, 8'h00, 8'h20, 8'h00, 8'd0, 8'd4, 1'b1));
      opening.push_back(make_record(8'h55, 8'hAA, 8'hAA, 8'h55, STATUS_DOWN, 8'd1, 1'b1));
      opening.push_back(make_record(EMPTY_BYTE, 8'hFF, EMPTY_BYTE, 8'hFF, 8'd0, 8'd0, 1'b1));
      opening.push_back(make_record(EMPTY_BYTE, 8'hFF, EMPTY_BYTE, 8'hFF, 8'd0, 8'd0, 1'b1));
      opening.push_back(make_record(8'h00, 8'hFF, 8'h00, 8'h0F, STATUS_DOWN, 8'd5, 1'b1));
      foreach (opening[i]) send_record(opening[i]);
      req_tvalid <= 1'b0;

      for (int phase = 0; phase < 9; phase++) begin
         wait_drained();
         send_idle_pct = (phase < 3) ? 33 : (phase < 6) ? 77 : 0;
         recv_idle_pct = (phase < 3) ? 77 : (phase < 6) ? 33 : 0;
         case (phase)
            0: apply_settings(0, 1, 1, 0, 0, 1, 10);
            1: apply_settings(1, 1, 1, 4095, 4095, 1, 1);
            2: begin
               write_reg(REG_UNUSED, $urandom_range(0, 4095), CSR_DATA_W);
               apply_settings(0, 0, 1, 1000, 3000, 0, 0);
            end
            3: apply_settings(0, 0, 0, 2048, 1536, 1, 15);
            default: apply_settings($urandom_range(0, 1), $urandom_range(0, 1),
                                    $urandom_range(0, 1), $urandom_range(0, 4095),
                                    $urandom_range(0, 4095), ($urandom_range(0, 7) != 0),
                                    $urandom_range(0, 15));
         endcase
         @(posedge clock);
         run_frames(PHASE_ITEMS);
      end

      wait_drained();
      if (pred.mismatches == 0 && pred.pending_reports.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
